>>> rtl/mrs_pkg.sv
package mrs_pkg;

    // default sizes
    localparam int RX_DEPTH_DEF      = 256;
    localparam int TX_DEPTH_DEF      = 256;
    localparam int TABLE_WORDS_DEF   = 64;
    localparam int MAX_READ_REGS_DEF = 125;

    // protocol constants
    localparam logic [7:0]  FC_READ_HOLDING   = 8'h03;
    localparam logic [7:0]  FC_WRITE_MULTIPLE = 8'h10;
    localparam logic [15:0] MAX_WRITE_REGS    = 16'd123;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  UNIT_ADDR_RESET   = 8'd1;

    // item operation codes
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_END  = 2'd1,
        OP_PULL = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // crc-16/modbus update by one byte, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/mrs_ram.sv
module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/modbus_rtu_register_server.sv
// Modbus RTU slave serving holding registers (function 0x03 read, 0x10 write).
// Received bytes (op 0) are taken one per cycle into the frame RAM while idle. A
// frame end (op 1) runs a sequencer: the frame goes through the CRC check, then a
// read writes reply header, register bytes and CRC, a write stores the registers
// and writes the echoed header and CRC; no item is taken meanwhile. A pull (op 2)
// reads the reply RAM when a reply byte is pending, taking no item meanwhile, and
// gives an empty item otherwise; a result waiting at the output does not block
// received bytes. After reset the register table is cleared before the first
// item is taken; configuration writes are taken at any time.
module modbus_rtu_register_server #(
    parameter int RX_DEPTH      = mrs_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH      = mrs_pkg::TX_DEPTH_DEF,
    parameter int TABLE_WORDS   = mrs_pkg::TABLE_WORDS_DEF,
    parameter int MAX_READ_REGS = mrs_pkg::MAX_READ_REGS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_tx_valid,
    output logic [8:0] o_tx_remaining,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import mrs_pkg::*;

    localparam int AW   = $clog2(RX_DEPTH);
    localparam int TXAW = $clog2(TX_DEPTH);
    localparam int TXLW = $clog2(TX_DEPTH + 1);
    localparam int TAW  = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
    localparam logic [AW-1:0]  RX_LAST  = AW'(RX_DEPTH - 1);
    localparam logic [16:0]    TAB_END  = 17'(TABLE_WORDS);
    localparam logic [17:0]    TX_LIM   = 18'(TX_DEPTH);
    localparam logic [15:0]    RD_MAX   = 16'(MAX_READ_REGS);

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_CRC   = 15'b000000000000100,
        S_CHECK = 15'b000000000001000,
        S_RHDR  = 15'b000000000010000,
        S_RREQ  = 15'b000000000100000,
        S_RHI   = 15'b000000001000000,
        S_RLO   = 15'b000000010000000,
        S_WREQ  = 15'b000000100000000,
        S_WLO   = 15'b000001000000000,
        S_WWR   = 15'b000010000000000,
        S_WHDR  = 15'b000100000000000,
        S_CRCLO = 15'b001000000000000,
        S_CRCHI = 15'b010000000000000,
        S_PULL  = 15'b100000000000000
    } t_state;

    t_state          r_state;
    logic [7:0]      r_unit;
    logic [AW-1:0]   r_rx_cnt;
    logic [AW-1:0]   r_flen;
    logic [AW-1:0]   r_idx;
    logic [AW-1:0]   r_didx;
    logic            r_pend;
    logic [15:0]     r_crc;
    logic [7:0]      r_hdr [6];
    logic [2:0]      r_cnt;
    logic [6:0]      r_i;
    logic [16:0]     r_taddr;
    logic            r_inr;
    logic [7:0]      r_lo;
    logic [7:0]      r_whi;
    logic [AW-1:0]   r_fptr;
    logic [TXAW-1:0] r_wp;
    logic [15:0]     r_rcrc;
    logic [TXLW-1:0] r_tx_len;
    logic [TXLW-1:0] r_tx_idx;
    logic            r_out_valid;
    logic [7:0]      r_tx_byte;
    logic            r_tx_valid;
    logic [8:0]      r_tx_rem;

    logic            in_acc;
    t_op             op;
    logic [15:0]     qty;
    logic [15:0]     start;
    logic [17:0]     rd_need;
    logic [17:0]     wr_need;
    logic            hdr_ok;

    logic            fr_we;
    logic [AW-1:0]   fr_raddr;
    logic [7:0]      fr_rdata;
    logic            rp_we;
    logic [7:0]      rp_wdata;
    logic            rp_crc_upd;
    logic [7:0]      rp_rdata;
    logic            tb_we;
    logic [15:0]     tb_wdata;
    logic [TAW-1:0]  tb_addr;
    logic [15:0]     tb_rdata;
    logic            tab_inr;

    assign op          = t_op'(i_op);
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && op == OP_PULL);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign start   = {r_hdr[2], r_hdr[3]};
    assign qty     = {r_hdr[4], r_hdr[5]};
    assign rd_need = 18'd5 + {1'b0, qty, 1'b0};
    assign wr_need = 18'd9 + {1'b0, qty, 1'b0};
    assign hdr_ok  = (r_hdr[0] == r_unit) && (r_crc == 16'h0000);
    assign tab_inr = r_taddr < TAB_END;
    assign tb_addr = r_taddr[TAW-1:0];

    // frame store
    assign fr_we = in_acc && op == OP_BYTE;

    always_comb begin
        fr_raddr = r_idx;
        if (r_state == S_WREQ) begin
            fr_raddr = r_fptr;
        end else if (r_state == S_WLO) begin
            fr_raddr = r_fptr + AW'(1);
        end
    end

    mrs_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (r_rx_cnt),
        .i_wdata (i_rx_byte),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    // reply byte write select
    always_comb begin
        rp_we      = 1'b0;
        rp_wdata   = r_hdr[0];
        rp_crc_upd = 1'b1;
        case (r_state)
            S_RHDR: begin
                rp_we = 1'b1;
                case (r_cnt)
                    3'd0:    rp_wdata = r_hdr[0];
                    3'd1:    rp_wdata = r_hdr[1];
                    default: rp_wdata = {qty[6:0], 1'b0};
                endcase
            end
            S_RHI: begin
                rp_we    = 1'b1;
                rp_wdata = r_inr ? tb_rdata[15:8] : 8'h00;
            end
            S_RLO: begin
                rp_we    = 1'b1;
                rp_wdata = r_lo;
            end
            S_WHDR: begin
                rp_we    = 1'b1;
                rp_wdata = r_hdr[r_cnt];
            end
            S_CRCLO: begin
                rp_we      = 1'b1;
                rp_wdata   = r_rcrc[7:0];
                rp_crc_upd = 1'b0;
            end
            S_CRCHI: begin
                rp_we      = 1'b1;
                rp_wdata   = r_rcrc[15:8];
                rp_crc_upd = 1'b0;
            end
            default: rp_we = 1'b0;
        endcase
    end

    mrs_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_reply_ram (
        .i_clk   (i_clk),
        .i_we    (rp_we),
        .i_waddr (r_wp),
        .i_wdata (rp_wdata),
        .i_raddr (r_tx_idx[TXAW-1:0]),
        .o_rdata (rp_rdata)
    );

    // register table: cleared after reset, written by function 0x10
    assign tb_we    = (r_state == S_CLEAR) || (r_state == S_WWR && tab_inr);
    assign tb_wdata = (r_state == S_CLEAR) ? 16'h0000 : {r_whi, fr_rdata};

    mrs_ram #(.WIDTH(16), .DEPTH(TABLE_WORDS)) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (tb_we),
        .i_waddr (tb_addr),
        .i_wdata (tb_wdata),
        .i_raddr (tb_addr),
        .o_rdata (tb_rdata)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= UNIT_ADDR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_unit <= i_cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_rx_cnt <= '0;
            r_tx_len <= '0;
            r_tx_idx <= '0;
            r_taddr  <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (rp_we) begin
                r_wp <= r_wp + TXAW'(1);
                if (rp_crc_upd) begin
                    r_rcrc <= crc16_byte(r_rcrc, rp_wdata);
                end
            end
            case (r_state)
                S_CLEAR: begin
                    r_taddr <= r_taddr + 17'd1;
                    if (r_taddr == TAB_END - 17'd1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        case (op)
                            OP_BYTE: begin
                                if (r_rx_cnt != RX_LAST) begin
                                    r_rx_cnt <= r_rx_cnt + AW'(1);
                                end
                            end
                            OP_END: begin
                                r_rx_cnt <= '0;
                                r_flen   <= r_rx_cnt;
                                r_idx    <= '0;
                                r_pend   <= 1'b0;
                                r_crc    <= CRC_INIT;
                                if (r_rx_cnt >= AW'(3)) begin
                                    r_state <= S_CRC;
                                end
                            end
                            OP_PULL: begin
                                if (r_tx_idx < r_tx_len) begin
                                    r_tx_idx <= r_tx_idx + TXLW'(1);
                                    r_state  <= S_PULL;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CRC: begin
                    // stream the frame through the crc, keep the header bytes
                    if (r_pend) begin
                        r_crc <= crc16_byte(r_crc, fr_rdata);
                        if (r_didx < AW'(6)) begin
                            r_hdr[r_didx[2:0]] <= fr_rdata;
                        end
                    end
                    if (r_idx < r_flen) begin
                        r_didx <= r_idx;
                        r_idx  <= r_idx + AW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_cnt   <= '0;
                    r_i     <= '0;
                    r_wp    <= '0;
                    r_rcrc  <= CRC_INIT;
                    r_taddr <= {1'b0, start};
                    r_fptr  <= AW'(7);
                    r_state <= S_IDLE;
                    if (hdr_ok && r_hdr[1] == FC_READ_HOLDING && qty != 16'd0 &&
                        qty <= RD_MAX && rd_need <= TX_LIM) begin
                        r_state <= S_RHDR;
                    end else if (hdr_ok && r_hdr[1] == FC_WRITE_MULTIPLE &&
                                 qty != 16'd0 && qty <= MAX_WRITE_REGS &&
                                 wr_need <= 18'(r_flen)) begin
                        r_state <= S_WREQ;
                    end
                end
                S_RHDR: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd2) begin
                        r_state <= S_RREQ;
                    end
                end
                S_RREQ: begin
                    r_inr <= tab_inr;
                    if (r_i == qty[6:0]) begin
                        r_state <= S_CRCLO;
                    end else begin
                        r_state <= S_RHI;
                    end
                end
                S_RHI: begin
                    r_lo    <= r_inr ? tb_rdata[7:0] : 8'h00;
                    r_state <= S_RLO;
                end
                S_RLO: begin
                    r_i     <= r_i + 7'd1;
                    r_taddr <= r_taddr + 17'd1;
                    r_state <= S_RREQ;
                end
                S_WREQ: begin
                    if (r_i == qty[6:0]) begin
                        r_cnt   <= '0;
                        r_state <= S_WHDR;
                    end else begin
                        r_state <= S_WLO;
                    end
                end
                S_WLO: begin
                    r_whi   <= fr_rdata;
                    r_state <= S_WWR;
                end
                S_WWR: begin
                    r_i     <= r_i + 7'd1;
                    r_taddr <= r_taddr + 17'd1;
                    r_fptr  <= r_fptr + AW'(2);
                    r_state <= S_WREQ;
                end
                S_WHDR: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd5) begin
                        r_state <= S_CRCLO;
                    end
                end
                S_CRCLO: r_state <= S_CRCHI;
                S_CRCHI: begin
                    r_tx_len <= TXLW'(r_wp) + TXLW'(1);
                    r_tx_idx <= '0;
                    r_state  <= S_IDLE;
                end
                S_PULL: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PULL) begin
            r_out_valid <= 1'b1;
            r_tx_byte   <= rp_rdata;
            r_tx_valid  <= 1'b1;
            r_tx_rem    <= 9'(r_tx_len - r_tx_idx);
        end else if (in_acc && op == OP_PULL && !(r_tx_idx < r_tx_len)) begin
            r_out_valid <= 1'b1;
            r_tx_byte   <= 8'h00;
            r_tx_valid  <= 1'b0;
            r_tx_rem    <= 9'd0;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_tx_byte      = r_tx_byte;
    assign o_tx_valid     = r_tx_valid;
    assign o_tx_remaining = r_tx_rem;

`ifndef SYNTHESIS
    // pull pointer never passes the reply length
    a_idx_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_idx <= r_tx_len)
        else $error("reply index past reply length");

    // an empty pull shows an all-zero item
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tx_valid) |-> (o_tx_byte == 8'h00 && o_tx_remaining == 9'd0))
        else $error("empty pull carries data");

    // a pull issued to the reply memory always ends in a valid item
    a_pull_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PULL) |=> (o_out_valid && o_tx_valid))
        else $error("pending reply byte lost");

    // no item taken while the sequencer is busy
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("item accepted during frame handling");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mrs_pkg::*;

    // one pulled reply byte as the block should hand it out
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [8:0] tx_remaining;
    } t_reply_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_op = OP_NONE;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_tx_byte;
    logic       o_tx_valid;
    logic [8:0] o_tx_remaining;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = 8'h00;

    // shadow of the slave state
    logic [7:0]  slave_addr;
    logic [7:0]  rx_frame [256];
    int          rx_count;
    logic [7:0]  tx_frame [256];
    int          tx_len;
    int          tx_pos;
    logic [15:0] hold_regs [64];

    t_reply_byte pending_bytes[$];
    int          fails = 0;
    int          items_sent = 0;
    int          bytes_checked = 0;
    int          replies_built = 0;
    bit          hold_off_req = 1'b0;

    modbus_rtu_register_server dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_op(i_op), .i_rx_byte(i_rx_byte),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_tx_byte(o_tx_byte), .o_tx_valid(o_tx_valid), .o_tx_remaining(o_tx_remaining),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // crc-16/modbus, one byte
    function automatic logic [15:0] crc_update(logic [15:0] c, logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void seal_tx(int n);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int k = 0; k < n; k++) c = crc_update(c, tx_frame[k]);
        tx_frame[n]     = c[7:0];
        tx_frame[n + 1] = c[15:8];
        tx_len = n + 2;
        tx_pos = 0;
        replies_built++;
    endfunction

    // examine the collected frame on a frame end
    function automatic void handle_frame();
        logic [15:0] c;
        int          first;
        int          qty;
        int          p;
        if (rx_count < 3 || rx_frame[0] != slave_addr) return;
        c = 16'hFFFF;
        for (int k = 0; k < rx_count; k++) c = crc_update(c, rx_frame[k]);
        if (c != 16'h0000) return;
        first = {rx_frame[2], rx_frame[3]};
        qty   = {rx_frame[4], rx_frame[5]};
        if (rx_frame[1] == FC_READ_HOLDING) begin
            if (qty == 0 || qty > 125 || 5 + 2 * qty > 256) return;
            tx_frame[0] = rx_frame[0];
            tx_frame[1] = rx_frame[1];
            tx_frame[2] = 8'(2 * qty);
            p = 3;
            for (int k = 0; k < qty; k++) begin
                logic [15:0] w;
                w = (first + k < 64) ? hold_regs[first + k] : 16'h0000;
                tx_frame[p]     = w[15:8];
                tx_frame[p + 1] = w[7:0];
                p += 2;
            end
            seal_tx(p);
        end else if (rx_frame[1] == FC_WRITE_MULTIPLE) begin
            if (qty == 0 || qty > int'(MAX_WRITE_REGS) || 9 + 2 * qty > rx_count) return;
            for (int k = 0; k < qty; k++) begin
                if (first + k < 64) hold_regs[first + k] = {rx_frame[7 + 2 * k], rx_frame[8 + 2 * k]};
            end
            for (int k = 0; k < 6; k++) tx_frame[k] = rx_frame[k];
            seal_tx(6);
        end
    endfunction

    // advance the shadow state by one accepted item
    function automatic void predict_item(t_op op, logic [7:0] d);
        t_reply_byte e;
        case (op)
            OP_BYTE: begin
                rx_frame[rx_count] = d;
                if (rx_count < 255) rx_count++;
            end
            OP_END: begin
                handle_frame();
                rx_count = 0;
            end
            OP_PULL: begin
                if (tx_pos < tx_len) begin
                    e.tx_byte = tx_frame[tx_pos];
                    e.tx_valid = 1'b1;
                    tx_pos++;
                    e.tx_remaining = 9'(tx_len - tx_pos);
                end else begin
                    e = '0;
                end
                pending_bytes.push_back(e);
            end
            default: ;
        endcase
    endfunction

    // send one item, holding valid high across back-to-back items
    task automatic send_item(t_op op, logic [7:0] d);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_rx_byte <= d;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(op, d);
        items_sent++;
    endtask

    task automatic send_frame(logic [7:0] q[$], bit add_crc);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (q[k]) c = crc_update(c, q[k]);
        if (add_crc) begin
            q.push_back(c[7:0]);
            q.push_back(c[15:8]);
        end
        foreach (q[k]) send_item(OP_BYTE, q[k]);
        send_item(OP_END, 8'($urandom));
    endtask

    task automatic pull_bytes(int n);
        repeat (n) send_item(OP_PULL, 8'($urandom));
    endtask

    task automatic drain_reply(int extra);
        pull_bytes(tx_len - tx_pos + extra);
    endtask

    function automatic void read_req(ref logic [7:0] q[$], input logic [7:0] a, input int first,
                                     input int qty);
        q = {a, FC_READ_HOLDING, 8'(first >> 8), 8'(first), 8'(qty >> 8), 8'(qty)};
    endfunction

    function automatic void write_req(ref logic [7:0] q[$], input logic [7:0] a, input int first,
                                      input int qty, input int words);
        q = {a, FC_WRITE_MULTIPLE, 8'(first >> 8), 8'(first), 8'(qty >> 8), 8'(qty),
             8'(2 * qty)};
        repeat (2 * words) q.push_back(8'($urandom));
    endfunction

    // wait for all results, then for any frame still being worked on
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        wait (pending_bytes.size() == 0);
        repeat (700) @(posedge i_clk);
    endtask

    task automatic write_addr(logic [7:0] a);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= a;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        slave_addr = a;
    endtask

    task automatic test_directed();
        logic [7:0] q[$];
        pull_bytes(1);                                  // nothing pending
        send_item(OP_NONE, 8'hFF);                      // ignored op
        read_req(q, slave_addr, 0, 3);   send_frame(q, 1); drain_reply(1);
        write_req(q, slave_addr, 0, 2, 2); send_frame(q, 1); drain_reply(0);
        // write across the table end, then read it back past the end
        write_req(q, slave_addr, 62, 3, 3); send_frame(q, 1); drain_reply(0);
        read_req(q, slave_addr, 61, 5); send_frame(q, 1); drain_reply(0);
        read_req(q, slave_addr, 16'hFFFF, 2); send_frame(q, 1); drain_reply(0);
        read_req(q, slave_addr, 0, 125); send_frame(q, 1); drain_reply(1);
        // dropped requests leave the old reply pending
        read_req(q, slave_addr, 0, 1);   send_frame(q, 1); pull_bytes(2);
        read_req(q, slave_addr, 0, 0);   send_frame(q, 1);
        read_req(q, slave_addr, 0, 126); send_frame(q, 1);
        write_req(q, slave_addr, 0, 0, 0);   send_frame(q, 1);
        write_req(q, slave_addr, 0, 124, 1); send_frame(q, 1);
        write_req(q, slave_addr, 0, 4, 3);   send_frame(q, 1);
        read_req(q, slave_addr, 0, 2);   q.push_back(8'h00); q.push_back(8'h00);
        send_frame(q, 0);                               // bad crc
        read_req(q, slave_addr + 8'd1, 0, 2); send_frame(q, 1);
        q = {slave_addr, 8'h04, 8'h00, 8'h00, 8'h00, 8'h01}; send_frame(q, 1);
        q = {slave_addr, 8'h03}; send_frame(q, 0);      // too short
        send_frame(q[0:0], 0);
        q = {};
        send_frame(q, 0);
        drain_reply(1);
        // overlong frame, last slot overwritten
        repeat (260) q.push_back(8'($urandom));
        send_frame(q, 0);
        pull_bytes(1);
    endtask

    task automatic random_request();
        logic [7:0] q[$];
        int         kind;
        int         first;
        int         qty;
        kind = $urandom_range(0, 9);
        first = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 70);
        qty = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 130) : $urandom_range(1, 8);
        if (kind < 5) begin
            read_req(q, slave_addr, first, qty);
        end else if (kind < 8) begin
            write_req(q, slave_addr, first, qty,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, qty) : qty);
        end else begin
            // line noise, never a plausible header of 3 to 5 bytes
            repeat ($urandom_range(0, 12)) q.push_back(8'($urandom));
            if (q.size() >= 3 && q.size() <= 5 && q[0] == slave_addr) q[0] = ~slave_addr;
            if (kind == 9) send_item(OP_NONE, 8'($urandom));
            send_frame(q, 0);
            pull_bytes($urandom_range(0, 2));
            return;
        end
        case ($urandom_range(0, 11))
            0: q[0] = slave_addr + 8'($urandom_range(1, 255));
            1: begin
                send_frame(q, 0);                       // missing crc
                return;
            end
            default: ;
        endcase
        q.push_back(8'h00);
        q.push_back(8'h00);
        void'(q.pop_back());
        void'(q.pop_back());
        if ($urandom_range(0, 11) == 0) begin
            logic [15:0] c;
            c = 16'hFFFF;
            foreach (q[k]) c = crc_update(c, q[k]);
            q.push_back(c[7:0]);
            q.push_back(c[15:8] ^ (8'd1 << $urandom_range(0, 7)));
            send_frame(q, 0);
        end else begin
            send_frame(q, 1);
        end
        if ($urandom_range(0, 4) == 0) pull_bytes($urandom_range(0, 3));
        else drain_reply($urandom_range(0, 1));
    endtask

    task automatic test_random(int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at) random_request();
    endtask

    task automatic test_addresses();
        logic [7:0] q[$];
        logic [7:0] vals[4] = '{8'h00, 8'hFF, 8'h00, 8'h01};
        foreach (vals[k]) begin
            write_addr(k == 2 ? 8'($urandom) : vals[k]);
            read_req(q, slave_addr, 0, 4); send_frame(q, 1); drain_reply(0);
            write_req(q, slave_addr, 4 * k, 2, 2); send_frame(q, 1); drain_reply(0);
            test_random(10);
        end
    endtask

    task automatic test_backpressure();
        logic [7:0] q[$];
        read_req(q, slave_addr, 0, 40);
        send_frame(q, 1);
        hold_off_req = 1'b1;
        drain_reply(5);
        // pause until every pulled byte has come out
        i_in_valid <= 1'b0;
        wait (pending_bytes.size() == 0);
        @(posedge i_clk);
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int n;
        forever begin
            n = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) n = 0;
            if (hold_off_req) begin
                n = 300;
                hold_off_req = 1'b0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_reply_byte e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected result: tx_byte %0h", o_tx_byte);
                fails++;
            end else begin
                e = pending_bytes.pop_front();
                bytes_checked++;
                if (o_tx_byte !== e.tx_byte) begin
                    $error("tx_byte: expected %0h actual %0h", e.tx_byte, o_tx_byte);
                    fails++;
                end
                if (o_tx_valid !== e.tx_valid) begin
                    $error("tx_valid: expected %0d actual %0d", e.tx_valid, o_tx_valid);
                    fails++;
                end
                if (o_tx_remaining !== e.tx_remaining) begin
                    $error("tx_remaining: expected %0d actual %0d",
                           e.tx_remaining, o_tx_remaining);
                    fails++;
                end
            end
        end
    end

    initial begin
        #30ms;
        $display("modbus_rtu_register_server test failed");
        $finish;
    end

    initial begin
        slave_addr = UNIT_ADDR_RESET;
        rx_count = 0;
        tx_len = 0;
        tx_pos = 0;
        foreach (hold_regs[k]) hold_regs[k] = 16'h0000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_addresses();
        test_random(30);
        wait_idle();
        $display("covered %0d items, %0d replies built, %0d reply bytes checked",
                 items_sent, replies_built, bytes_checked);
        $display("slave addresses 0, 255, random and 1; range, count and crc rejects");
        if (fails == 0) begin
            $display("modbus_rtu_register_server test passed");
        end else begin
            $display("modbus_rtu_register_server test failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/mrs_pkg.sv
rtl/mrs_ram.sv
rtl/modbus_rtu_register_server.sv
dv/tb.sv
